FILE: rtl/hcfb_pkg.sv
// ----------------------------------------------------------------------------
// hcfb_pkg
// Shared types and constants for the host command frame builder.
// ----------------------------------------------------------------------------
package hcfb_pkg;

    localparam logic [7:0] PREAMBLE    = 8'h00;
    localparam logic [7:0] START_CODE1 = 8'h00;
    localparam logic [7:0] START_CODE2 = 8'hFF;
    localparam logic [7:0] POSTAMBLE   = 8'h00;
    localparam logic [7:0] DIR_HOST    = 8'hD4;

    // Legal payload length range; values outside are pulled to the nearest end.
    localparam logic [7:0] LEN_MIN = 8'd1;
    localparam logic [7:0] LEN_MAX = 8'd254;

    localparam int QUEUE_DEPTH = 4;

    // One classified payload byte, handed from the front part to the back part.
    typedef struct packed {
        logic       first;   // opens a frame: header bytes go out ahead of it
        logic       last;    // closes a frame: trailer bytes follow it
        logic [7:0] data;    // the payload byte
        logic [7:0] len_b;   // LEN byte (payload length plus one)
        logic [7:0] len_ck;  // length checksum
        logic [7:0] data_ck; // data checksum
    } t_cmd;

    // Position in the frame of the byte the back part emits next.
    typedef enum logic [3:0] {
        S_PRE,
        S_START1,
        S_START2,
        S_LEN,
        S_LCS,
        S_DIR,
        S_DATA,
        S_DCS,
        S_POST
    } t_step;

endpackage

FILE: rtl/host_command_frame_builder_top.sv
// ----------------------------------------------------------------------------
// host_command_frame_builder_top
// Wraps host command payload bytes into normal information frames.
// ----------------------------------------------------------------------------
// Usage: each beat on the slave stream carries one payload byte. The first
// beat of a frame also carries the payload length (1 to 254; zero is taken as
// one and 255 as 254); on later beats the length is ignored. The master
// stream carries the framed bytes: preamble, start code, LEN, length
// checksum, direction byte, the payload, data checksum and postamble. tlast
// is high on the postamble beat.
// Flow: an accepted item goes through the queue, and the back part loads its
// first output byte into the output register. A mid-frame byte yields one output
// byte; a first byte also yields the six header bytes ahead of it, a last byte
// the data checksum and postamble after it. The sequencer emits one byte per
// cycle while the receiver takes them. The front part keeps taking beats into a
// QUEUE_DEPTH-entry queue while the back part works through header or trailer
// bytes, and stalls only when that queue is full.
// Reset clears the frame tracking, empties the queue and drops o_m_axis_tvalid.
// When the receiver holds i_m_axis_tready low, the output register holds its
// beat, the sequencer waits, and the queue fills until the slave side stalls.
// ----------------------------------------------------------------------------
module host_command_frame_builder_top #(
    parameter int QUEUE_DEPTH = hcfb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] data_byte, [15:8] payload_length
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast    // last_of_frame
);

    hcfb_pkg::t_cmd push_cmd;
    hcfb_pkg::t_cmd head_cmd;
    logic           push;
    logic           full;
    logic           head_valid;
    logic           pop;

    // Front: classifies each beat and computes length and checksum bytes.
    hcfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_data_byte      (i_s_axis_tdata[7:0]),
        .i_payload_length (i_s_axis_tdata[15:8]),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // Queue decouples the front from the byte sequencer.
    hcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    // Back: expands each entry into its frame bytes.
    hcfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: rtl/hcfb_front.sv
// ----------------------------------------------------------------------------
// hcfb_front
// Accepts payload bytes, tracks the frame and works out length and checksums.
// ----------------------------------------------------------------------------
module hcfb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_payload_length,
    input  logic              i_full,
    output logic              o_push,
    output hcfb_pkg::t_cmd    o_cmd
);

    logic       r_in_frame;
    logic [7:0] r_bytes_left;
    logic [7:0] r_sum;

    logic       n_in_frame;
    logic [7:0] n_bytes_left;
    logic [7:0] n_sum;

    logic [7:0] len;
    logic [7:0] len_b;
    logic [7:0] left_next;
    logic [7:0] sum_next;
    logic       last;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        // Clamp the length into the supported range.
        if (i_payload_length < hcfb_pkg::LEN_MIN) begin
            len = hcfb_pkg::LEN_MIN;
        end else if (i_payload_length > hcfb_pkg::LEN_MAX) begin
            len = hcfb_pkg::LEN_MAX;
        end else begin
            len = i_payload_length;
        end
        len_b = len + 8'd1;

        if (!r_in_frame) begin
            sum_next  = i_data_byte;
            left_next = len - 8'd1;
        end else begin
            sum_next  = r_sum + i_data_byte;
            left_next = (r_bytes_left != 8'd0) ? r_bytes_left - 8'd1 : 8'd0;
        end
        last = (left_next == 8'd0);

        o_cmd.first   = !r_in_frame;
        o_cmd.last    = last;
        o_cmd.data    = i_data_byte;
        o_cmd.len_b   = len_b;
        o_cmd.len_ck  = 8'd0 - len_b;
        o_cmd.data_ck = 8'd0 - (hcfb_pkg::DIR_HOST + sum_next);

        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        if (o_push) begin
            n_in_frame   = !last;
            n_bytes_left = last ? 8'd0 : left_next;
            n_sum        = last ? 8'd0 : sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
        end
    end

endmodule

FILE: rtl/hcfb_queue.sv
// ----------------------------------------------------------------------------
// hcfb_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hcfb_queue #(
    parameter int DEPTH = hcfb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hcfb_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output hcfb_pkg::t_cmd    o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hcfb_pkg::t_cmd r_mem [DEPTH];

    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/hcfb_back.sv
// ----------------------------------------------------------------------------
// hcfb_back
// Sequences header, payload and trailer bytes into the output register.
// ----------------------------------------------------------------------------
module hcfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hcfb_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [7:0]        o_tdata,
    output logic              o_tlast
);

    hcfb_pkg::t_step r_step;
    hcfb_pkg::t_step n_step;
    hcfb_pkg::t_step cur;
    logic            r_busy;
    logic            n_busy;

    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    logic            load;
    logic            at_end;
    logic [7:0]      sel_byte;

    assign load = i_valid && (!r_out_valid || i_tready);

    // Next-state logic of the frame sequencer.
    always_comb begin
        if (r_busy) begin
            cur = r_step;
        end else if (i_cmd.first) begin
            cur = hcfb_pkg::S_PRE;
        end else begin
            cur = hcfb_pkg::S_DATA;
        end
        at_end = (cur == hcfb_pkg::S_POST) || ((cur == hcfb_pkg::S_DATA) && !i_cmd.last);

        n_step = r_step;
        n_busy = r_busy;
        if (load) begin
            if (at_end) begin
                n_busy = 1'b0;
                n_step = hcfb_pkg::S_PRE;
            end else begin
                n_busy = 1'b1;
                n_step = hcfb_pkg::t_step'(cur + 4'd1);
            end
        end
    end

    // Output logic: the byte for the current position.
    always_comb begin
        o_pop = load && at_end;
        case (cur)
            hcfb_pkg::S_PRE:    sel_byte = hcfb_pkg::PREAMBLE;
            hcfb_pkg::S_START1: sel_byte = hcfb_pkg::START_CODE1;
            hcfb_pkg::S_START2: sel_byte = hcfb_pkg::START_CODE2;
            hcfb_pkg::S_LEN:    sel_byte = i_cmd.len_b;
            hcfb_pkg::S_LCS:    sel_byte = i_cmd.len_ck;
            hcfb_pkg::S_DIR:    sel_byte = hcfb_pkg::DIR_HOST;
            hcfb_pkg::S_DATA:   sel_byte = i_cmd.data;
            hcfb_pkg::S_DCS:    sel_byte = i_cmd.data_ck;
            hcfb_pkg::S_POST:   sel_byte = hcfb_pkg::POSTAMBLE;
            default:            sel_byte = hcfb_pkg::PREAMBLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= hcfb_pkg::S_PRE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_last <= (cur == hcfb_pkg::S_POST);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;

endmodule
